FILE: design/qcs_pkg.sv
package qcs_pkg;

   // Default geometry
   localparam int DEF_IMAGE_WIDTH = 32;
   localparam int DEF_CHANNELS    = 3;
   localparam int DEF_KERNEL      = 5;
   localparam int DEF_FILTERS     = 8;

   // Fixed-point constants
   localparam int SCALE_W   = 32;
   localparam int FRAC_BITS = 28;
   localparam int ACC_BITS  = 24;
   localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h1000_0000;

   // Item commands
   localparam logic [2:0] CMD_LOAD_WEIGHT = 3'd0;
   localparam logic [2:0] CMD_LOAD_BIAS   = 3'd1;
   localparam logic [2:0] CMD_LOAD_WSCALE = 3'd2;
   localparam logic [2:0] CMD_LOAD_BSCALE = 3'd3;
   localparam logic [2:0] CMD_SAMPLE      = 3'd4;

   // Register indexes
   localparam logic [1:0] CSR_IN_ZP     = 2'd0;
   localparam logic [1:0] CSR_OUT_ZP    = 2'd1;
   localparam logic [1:0] CSR_IN_SCALE  = 2'd2;
   localparam logic [1:0] CSR_OUT_SCALE = 2'd3;

   typedef struct packed {
      logic [2:0]         command;
      logic [9:0]         index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [7:0] activation;
      logic [5:0]        filter_number;
      logic              last_of_window;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_QREAD,
      S_QMUL,
      S_QSUM,
      S_QOUT,
      S_OUT,
      S_SMUL,
      S_DLOAD,
      S_DIV,
      S_DROUND,
      S_DWRITE
   } state_type;

   typedef struct packed {
      logic accept;
      logic mac_issue;
      logic filt_next;
      logic q_read;
      logic q_mul;
      logic q_sum;
      logic q_out;
      logic s_mul;
      logic d_load;
      logic d_step;
      logic d_round;
      logic d_write;
   } dp_cmd_type;

   typedef struct packed {
      logic window_close;
      logic scale_load;
      logic last_elem;
      logic pipe_busy;
      logic last_filter;
      logic div_last;
   } dp_status_type;

endpackage

FILE: design/quantized_conv2d_stream_unit.sv
// Weight and bias loads are written on accept; a scale load goes through multiply,
//   divider load, bit-serial divider, round and write before the next item is taken.
// A sample that closes a window holds the input until the last filter's result is taken,
//   output stalls included; each filter's K*K*C products go through the single shared
//   MAC, one per cycle, then drain, requantize (read, multiply, sum, register) and output.
// The unit takes one item at a time: no new item is accepted until the last is done.
// Reset (synchronous, active high) clears raster position, line pointer and zero points, and sets both scales to one.
module quantized_conv2d_stream_unit import qcs_pkg::*; #(
   parameter int IMAGE_WIDTH = DEF_IMAGE_WIDTH,
   parameter int CHANNELS    = DEF_CHANNELS,
   parameter int KERNEL      = DEF_KERNEL,
   parameter int FILTERS     = DEF_FILTERS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   // Controller sequences the item; datapath holds stores, MAC, requantizer, divider.
   dp_cmd_type    cmd;
   dp_status_type status;

   qcs_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: line store, weight store, per-filter tables, MAC and scale divider.
   qcs_dp #(
      .IMAGE_WIDTH (IMAGE_WIDTH),
      .CHANNELS    (CHANNELS),
      .KERNEL      (KERNEL),
      .FILTERS     (FILTERS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: design/qcs_ram.sv
module qcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/qcs_dp.sv
module qcs_dp import qcs_pkg::*; #(
   parameter int IMAGE_WIDTH = DEF_IMAGE_WIDTH,
   parameter int CHANNELS    = DEF_CHANNELS,
   parameter int KERNEL      = DEF_KERNEL,
   parameter int FILTERS     = DEF_FILTERS
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  req_type       req_data,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wr_data,
   output rsp_type       rsp_data
);

   localparam int WIN_ELEMS    = KERNEL * KERNEL * CHANNELS;
   localparam int WEIGHT_COUNT = FILTERS * WIN_ELEMS;
   localparam int ROW_SPAN     = IMAGE_WIDTH * CHANNELS;
   localparam int LINE_DEPTH   = (KERNEL - 1) * ROW_SPAN + KERNEL * CHANNELS;
   localparam int ROW_STEP     = ROW_SPAN - KERNEL * CHANNELS + 1;
   localparam int LA_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int WA_W = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
   localparam int FA_W = (FILTERS > 1) ? $clog2(FILTERS) : 1;
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PX_W = $clog2(IMAGE_WIDTH);
   localparam int KC_W = (KERNEL > 1) ? $clog2(KERNEL) : 1;

   // configuration
   logic signed [7:0]  izp_ff, izp_in, ozp_ff, ozp_in;
   logic [31:0]        iscale_ff, iscale_in, oscale_ff, oscale_in;

   // latched item
   req_type            item_ff, item_in;

   // raster position
   logic [LA_W-1:0]    wp_ff, wp_in, wp_next;
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic [PX_W-1:0]    col_ff, col_in, row_ff, row_in;

   // window walk
   logic [LA_W-1:0]    win_base_ff, win_base_in, rd_ptr_ff, rd_ptr_in;
   logic [LA_W:0]      ptr_sum;
   logic [KC_W-1:0]    kr_ff, kr_in, kc_ff, kc_in;
   logic [CH_W-1:0]    kch_ff, kch_in;
   logic [WA_W-1:0]    waddr_ff, waddr_in;
   logic [FA_W-1:0]    filt_ff, filt_in;
   logic               pv1_ff, pv1_in, pv2_ff, pv2_in;
   logic signed [16:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   logic signed [8:0]  xdiff;

   // requantize
   logic signed [55:0] p1_ff, p1_in;
   logic signed [47:0] p2_ff, p2_in;
   logic signed [56:0] sum_ff, sum_in, rnd_sum;
   logic [7:0]         r8;
   logic signed [9:0]  act10;
   rsp_type            rsp_ff, rsp_in;

   // scale divider
   logic signed [63:0] num_ff, num_in;
   logic [63:0]        dq_ff, dq_in;
   logic [31:0]        drem_ff, drem_in, dden_ff, dden_in, dmag_ff, dmag_in;
   logic               dneg_ff, dneg_in, dzero_ff, dzero_in;
   logic [5:0]         dcnt_ff, dcnt_in;
   logic [32:0]        rem_sh;
   logic               rnd_up;
   logic [64:0]        q1;
   logic [31:0]        mult_word;

   // decode
   logic               is_sample, is_weight, is_bias, is_scale;
   logic               filter_ok, weight_ok;

   // memory ports
   logic [7:0]         line_rd, wt_rd;
   logic [15:0]        bias_rd;
   logic [31:0]        wmul_rd, bmul_rd;

   always_comb begin
      is_sample = 1'b0;
      is_weight = 1'b0;
      is_bias   = 1'b0;
      is_scale  = 1'b0;
      case (req_data.command)
         CMD_LOAD_WEIGHT: is_weight = 1'b1;
         CMD_LOAD_BIAS:   is_bias   = 1'b1;
         CMD_LOAD_WSCALE: is_scale  = 1'b1;
         CMD_LOAD_BSCALE: is_scale  = 1'b1;
         CMD_SAMPLE:      is_sample = 1'b1;
         default:         is_sample = 1'b0;
      endcase
      filter_ok = {22'd0, req_data.index} < 32'(FILTERS);
      weight_ok = {22'd0, req_data.index} < 32'(WEIGHT_COUNT);
   end

   // configuration writes
   always_comb begin
      izp_in    = izp_ff;
      ozp_in    = ozp_ff;
      iscale_in = iscale_ff;
      oscale_in = oscale_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IN_ZP:     izp_in    = csr_wr_data[7:0];
            CSR_OUT_ZP:    ozp_in    = csr_wr_data[7:0];
            CSR_IN_SCALE:  iscale_in = csr_wr_data;
            CSR_OUT_SCALE: oscale_in = csr_wr_data;
            default:       izp_in    = izp_ff;
         endcase
      end
   end

   // raster position and line store pointer
   always_comb begin
      wp_next = (wp_ff == LA_W'(LINE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      wp_in   = wp_ff;
      ch_in   = ch_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (cmd.accept && is_sample) begin
         wp_in = wp_next;
         if (ch_ff == CH_W'(CHANNELS - 1)) begin
            ch_in = '0;
            if (col_ff == PX_W'(IMAGE_WIDTH - 1)) begin
               col_in = '0;
               row_in = (row_ff == PX_W'(IMAGE_WIDTH - 1)) ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end else begin
            ch_in = ch_ff + 1'b1;
         end
      end
   end

   assign status.window_close = is_sample && (ch_ff == CH_W'(CHANNELS - 1)) &&
                                (row_ff >= PX_W'(KERNEL - 1)) &&
                                (col_ff >= PX_W'(KERNEL - 1));
   assign status.scale_load   = is_scale && filter_ok;
   assign status.last_elem    = (kch_ff == CH_W'(CHANNELS - 1)) &&
                                (kc_ff == KC_W'(KERNEL - 1)) &&
                                (kr_ff == KC_W'(KERNEL - 1));
   assign status.pipe_busy    = pv1_ff || pv2_ff;
   assign status.last_filter  = filt_ff == FA_W'(FILTERS - 1);
   assign status.div_last     = dcnt_ff == 6'd63;

   // window walk: address generator and MAC
   always_comb begin
      win_base_in = win_base_ff;
      rd_ptr_in   = rd_ptr_ff;
      kr_in       = kr_ff;
      kc_in       = kc_ff;
      kch_in      = kch_ff;
      waddr_in    = waddr_ff;
      filt_in     = filt_ff;
      if ((kch_ff == CH_W'(CHANNELS - 1)) && (kc_ff == KC_W'(KERNEL - 1))) begin
         ptr_sum = {1'b0, rd_ptr_ff} + (LA_W + 1)'(ROW_STEP);
      end else begin
         ptr_sum = {1'b0, rd_ptr_ff} + (LA_W + 1)'(1);
      end
      if (cmd.accept && status.window_close) begin
         win_base_in = wp_next;
         rd_ptr_in   = wp_next;
         kr_in       = '0;
         kc_in       = '0;
         kch_in      = '0;
         waddr_in    = '0;
         filt_in     = '0;
      end else if (cmd.filt_next) begin
         rd_ptr_in = win_base_ff;
         kr_in     = '0;
         kc_in     = '0;
         kch_in    = '0;
         filt_in   = filt_ff + 1'b1;
      end else if (cmd.mac_issue) begin
         if (ptr_sum >= (LA_W + 1)'(LINE_DEPTH)) begin
            rd_ptr_in = LA_W'(ptr_sum - (LA_W + 1)'(LINE_DEPTH));
         end else begin
            rd_ptr_in = ptr_sum[LA_W-1:0];
         end
         waddr_in = waddr_ff + 1'b1;
         if (kch_ff == CH_W'(CHANNELS - 1)) begin
            kch_in = '0;
            if (kc_ff == KC_W'(KERNEL - 1)) begin
               kc_in = '0;
               kr_in = kr_ff + 1'b1;
            end else begin
               kc_in = kc_ff + 1'b1;
            end
         end else begin
            kch_in = kch_ff + 1'b1;
         end
      end

      pv1_in  = cmd.mac_issue;
      pv2_in  = pv1_ff;
      xdiff   = 9'(signed'(line_rd)) - 9'(izp_ff);
      prod_in = xdiff * signed'(wt_rd);
      acc_in  = acc_ff;
      if ((cmd.accept && status.window_close) || cmd.filt_next) begin
         acc_in = '0;
      end else if (pv2_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   // requantize one filter result
   always_comb begin
      p1_in  = p1_ff;
      p2_in  = p2_ff;
      sum_in = sum_ff;
      rsp_in = rsp_ff;
      if (cmd.q_mul) begin
         p1_in = acc_ff * signed'(wmul_rd);
         p2_in = signed'(bias_rd) * signed'(bmul_rd);
      end
      if (cmd.q_sum) begin
         sum_in = 57'(p1_ff) + 57'(p2_ff);
      end
      rnd_sum = sum_ff + 57'sd134217728;
      if (sum_ff > 57'sd0) begin
         r8 = (|rnd_sum[56:36]) ? 8'd255 : rnd_sum[35:28];
      end else begin
         r8 = 8'd0;
      end
      act10 = signed'({2'b00, r8}) + 10'(ozp_ff);
      if (cmd.q_out) begin
         rsp_in.activation     = (act10 > 10'sd127) ? 8'sd127 : act10[7:0];
         rsp_in.filter_number  = 6'(filt_ff);
         rsp_in.last_of_window = status.last_filter;
      end
   end

   // scale load: multiply, then restoring divide one bit per cycle
   always_comb begin
      num_in   = num_ff;
      dq_in    = dq_ff;
      drem_in  = drem_ff;
      dden_in  = dden_ff;
      dneg_in  = dneg_ff;
      dzero_in = dzero_ff;
      dcnt_in  = dcnt_ff;
      dmag_in  = dmag_ff;
      rem_sh   = {drem_ff, dq_ff[63]};
      rnd_up   = {drem_ff, 1'b0} >= {1'b0, dden_ff};
      q1       = {1'b0, dq_ff} + 65'(rnd_up);
      if (cmd.s_mul) begin
         if (item_ff.command == CMD_LOAD_WSCALE) begin
            num_in = signed'(iscale_ff) * item_ff.value;
         end else begin
            num_in = 64'(item_ff.value) <<< FRAC_BITS;
         end
      end
      if (cmd.d_load) begin
         dq_in    = num_ff[63] ? 64'(-num_ff) : num_ff;
         dden_in  = oscale_ff[31] ? 32'(-oscale_ff) : oscale_ff;
         dneg_in  = num_ff[63] ^ oscale_ff[31];
         dzero_in = oscale_ff == 32'd0;
         drem_in  = '0;
         dcnt_in  = '0;
      end
      if (cmd.d_step) begin
         dcnt_in = dcnt_ff + 1'b1;
         if (rem_sh >= {1'b0, dden_ff}) begin
            drem_in = 32'(rem_sh - {1'b0, dden_ff});
            dq_in   = {dq_ff[62:0], 1'b1};
         end else begin
            drem_in = rem_sh[31:0];
            dq_in   = {dq_ff[62:0], 1'b0};
         end
      end
      if (cmd.d_round) begin
         if (dneg_ff && (q1 > 65'h8000_0000)) begin
            dmag_in = 32'h8000_0000;
         end else if (!dneg_ff && (q1 > 65'h7FFF_FFFF)) begin
            dmag_in = 32'h7FFF_FFFF;
         end else begin
            dmag_in = q1[31:0];
         end
      end
      if (dzero_ff) begin
         mult_word = '0;
      end else if (dneg_ff) begin
         mult_word = 32'(-dmag_ff);
      end else begin
         mult_word = dmag_ff;
      end
   end

   assign item_in = cmd.accept ? req_data : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         izp_ff    <= '0;
         ozp_ff    <= '0;
         iscale_ff <= SCALE_ONE;
         oscale_ff <= SCALE_ONE;
         wp_ff     <= '0;
         ch_ff     <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         pv1_ff    <= 1'b0;
         pv2_ff    <= 1'b0;
         kr_ff     <= '0;
         kc_ff     <= '0;
         kch_ff    <= '0;
         waddr_ff  <= '0;
         filt_ff   <= '0;
         dcnt_ff   <= '0;
      end else begin
         izp_ff    <= izp_in;
         ozp_ff    <= ozp_in;
         iscale_ff <= iscale_in;
         oscale_ff <= oscale_in;
         wp_ff     <= wp_in;
         ch_ff     <= ch_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pv1_ff    <= pv1_in;
         pv2_ff    <= pv2_in;
         kr_ff     <= kr_in;
         kc_ff     <= kc_in;
         kch_ff    <= kch_in;
         waddr_ff  <= waddr_in;
         filt_ff   <= filt_in;
         dcnt_ff   <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      win_base_ff <= win_base_in;
      rd_ptr_ff   <= rd_ptr_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      sum_ff      <= sum_in;
      rsp_ff      <= rsp_in;
      num_ff      <= num_in;
      dq_ff       <= dq_in;
      drem_ff     <= drem_in;
      dden_ff     <= dden_in;
      dneg_ff     <= dneg_in;
      dzero_ff    <= dzero_in;
      dmag_ff     <= dmag_in;
   end

   assign rsp_data = rsp_ff;

   qcs_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.accept && is_sample),
      .wr_addr (wp_ff),
      .wr_data (req_data.value[7:0]),
      .rd_en   (cmd.mac_issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (line_rd)
   );

   qcs_ram #(.WIDTH(8), .DEPTH(WEIGHT_COUNT)) u_weight_ram (
      .clock   (clock),
      .wr_en   (cmd.accept && is_weight && weight_ok),
      .wr_addr (WA_W'(req_data.index)),
      .wr_data (req_data.value[7:0]),
      .rd_en   (cmd.mac_issue),
      .rd_addr (waddr_ff),
      .rd_data (wt_rd)
   );

   qcs_ram #(.WIDTH(16), .DEPTH(FILTERS)) u_bias_ram (
      .clock   (clock),
      .wr_en   (cmd.accept && is_bias && filter_ok),
      .wr_addr (FA_W'(req_data.index)),
      .wr_data (req_data.value[15:0]),
      .rd_en   (cmd.q_read),
      .rd_addr (filt_ff),
      .rd_data (bias_rd)
   );

   qcs_ram #(.WIDTH(32), .DEPTH(FILTERS)) u_wmul_ram (
      .clock   (clock),
      .wr_en   (cmd.d_write && (item_ff.command == CMD_LOAD_WSCALE)),
      .wr_addr (FA_W'(item_ff.index)),
      .wr_data (mult_word),
      .rd_en   (cmd.q_read),
      .rd_addr (filt_ff),
      .rd_data (wmul_rd)
   );

   qcs_ram #(.WIDTH(32), .DEPTH(FILTERS)) u_bmul_ram (
      .clock   (clock),
      .wr_en   (cmd.d_write && (item_ff.command == CMD_LOAD_BSCALE)),
      .wr_addr (FA_W'(item_ff.index)),
      .wr_data (mult_word),
      .rd_en   (cmd.q_read),
      .rd_addr (filt_ff),
      .rd_data (bmul_rd)
   );

endmodule

FILE: design/qcs_ctl.sv
module qcs_ctl import qcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && status.window_close) begin
               state_in = S_MAC;
            end else if (req_valid && status.scale_load) begin
               state_in = S_SMUL;
            end
         end
         S_MAC:    if (status.last_elem) state_in = S_DRAIN;
         S_DRAIN:  if (!status.pipe_busy) state_in = S_QREAD;
         S_QREAD:  state_in = S_QMUL;
         S_QMUL:   state_in = S_QSUM;
         S_QSUM:   state_in = S_QOUT;
         S_QOUT:   state_in = S_OUT;
         S_OUT: begin
            if (rsp_ready) begin
               state_in = status.last_filter ? S_IDLE : S_MAC;
            end
         end
         S_SMUL:   state_in = S_DLOAD;
         S_DLOAD:  state_in = S_DIV;
         S_DIV:    if (status.div_last) state_in = S_DROUND;
         S_DROUND: state_in = S_DWRITE;
         S_DWRITE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_MAC:    cmd.mac_issue = 1'b1;
         S_QREAD:  cmd.q_read    = 1'b1;
         S_QMUL:   cmd.q_mul     = 1'b1;
         S_QSUM:   cmd.q_sum     = 1'b1;
         S_QOUT:   cmd.q_out     = 1'b1;
         S_OUT: begin
            rsp_valid     = 1'b1;
            cmd.filt_next = rsp_ready && !status.last_filter;
         end
         S_SMUL:   cmd.s_mul   = 1'b1;
         S_DLOAD:  cmd.d_load  = 1'b1;
         S_DIV:    cmd.d_step  = 1'b1;
         S_DROUND: cmd.d_round = 1'b1;
         S_DWRITE: cmd.d_write = 1'b1;
         default:  cmd         = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted while a result is pending");

   a_drained_before_requant: assert property (@(posedge clock) disable iff (reset)
      cmd.q_read |-> !status.pipe_busy)
      else $error("requantize started with MAC products in flight");

   a_idle_after_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && status.last_filter) |=> req_ready)
      else $error("not idle after last filter of window");

   a_pending_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("pending result dropped");
`endif

endmodule

FILE: tb/tb.sv
module tb import qcs_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IMG      = DEF_IMAGE_WIDTH;
   localparam int CHN      = DEF_CHANNELS;
   localparam int KER      = DEF_KERNEL;
   localparam int FLT      = DEF_FILTERS;
   localparam int WIN      = KER * KER * CHN;
   localparam int WCOUNT   = FLT * WIN;
   localparam int ROW_SPAN = IMG * CHN;
   localparam int LDEPTH   = (KER - 1) * ROW_SPAN + KER * CHN;
   // long enough for one window to finish, padded
   localparam int DRAIN_CYCLES = FLT * (WIN + 8) + 100;
   localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
   localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
   localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wr_data = '0;

   quantized_conv2d_stream_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the convolution state
   int                 in_zp, out_zp;
   logic signed [31:0] shadow_iscale, shadow_oscale;
   logic signed [7:0]  line_mem [LDEPTH];
   logic signed [7:0]  weight_mem [WCOUNT];
   logic signed [15:0] bias_mem [FLT];
   logic signed [31:0] weight_mult [FLT];
   logic signed [31:0] bias_mult [FLT];
   int                 line_wp, pix_row, pix_col, chan_cnt;

   req_type pending_items[$];
   rsp_type expected_acts[$];
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      hold_left = 0;
   bit      hold_req = 0;
   bit      req_fire = 0;
   int      errors = 0;

   // Round half away from zero, saturate to int32, zero divisor gives zero.
   function automatic logic signed [31:0] scale_div(longint num, longint den);
      longint unsigned an, ad, q, r;
      bit neg;
      if (den == 0) return '0;
      an  = (num < 0) ? longint'(-num) : num;
      ad  = (den < 0) ? longint'(-den) : den;
      neg = (num < 0) != (den < 0);
      q   = an / ad;
      r   = an % ad;
      if (r >= ad - r) q++;
      if (neg) begin
         if (q > 64'd2147483648) q = 64'd2147483648;
         return 32'(-longint'(q));
      end
      if (q > 64'd2147483647) q = 64'd2147483647;
      return 32'(q);
   endfunction

   function automatic logic signed [7:0] filter_act(int f);
      longint acc, s, r, o;
      logic signed [23:0] a24;
      int widx, pos;
      acc  = 0;
      widx = f * WIN;
      for (int row = 0; row < KER; row++)
         for (int col = 0; col < KER; col++)
            for (int ch = 0; ch < CHN; ch++) begin
               pos = (line_wp + row * ROW_SPAN + col * CHN + ch) % LDEPTH;
               acc += (longint'(line_mem[pos]) - in_zp) * longint'(weight_mem[widx]);
               widx++;
            end
      // wrap the accumulator to 24 bits, then requantize exactly
      a24 = acc[23:0];
      s = longint'(a24) * longint'(weight_mult[f]) +
          longint'(bias_mem[f]) * longint'(bias_mult[f]);
      r = (s > 0) ? ((s + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS) : 0;
      if (r > 255) r = 255;
      o = r + out_zp;
      if (o > 127) o = 127;
      if (o < -128) o = -128;
      return o[7:0];
   endfunction

   // Advance the shadow state by one accepted item and queue its results.
   task automatic predict_item(req_type it);
      rsp_type res;
      longint  val;
      val = longint'($signed(it.value));
      case (it.command)
         CMD_LOAD_WEIGHT: if (it.index < WCOUNT) weight_mem[it.index] = it.value[7:0];
         CMD_LOAD_BIAS:   if (it.index < FLT) bias_mem[it.index] = it.value[15:0];
         CMD_LOAD_WSCALE: if (it.index < FLT)
            weight_mult[it.index] = scale_div(longint'(shadow_iscale) * val,
                                              longint'(shadow_oscale));
         CMD_LOAD_BSCALE: if (it.index < FLT)
            bias_mult[it.index] = scale_div(val * (64'sd1 <<< FRAC_BITS),
                                            longint'(shadow_oscale));
         CMD_SAMPLE: begin
            line_mem[line_wp] = it.value[7:0];
            line_wp = (line_wp + 1) % LDEPTH;
            chan_cnt++;
            if (chan_cnt >= CHN) begin
               chan_cnt = 0;
               if (pix_row >= KER - 1 && pix_col >= KER - 1)
                  for (int f = 0; f < FLT; f++) begin
                     res.activation     = filter_act(f);
                     res.filter_number  = 6'(f);
                     res.last_of_window = (f == FLT - 1);
                     expected_acts.push_back(res);
                  end
               pix_col++;
               if (pix_col >= IMG) begin
                  pix_col = 0;
                  pix_row++;
                  if (pix_row >= IMG) pix_row = 0;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Sample acceptances at the rising edge; predict from the accepted item.
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) predict_item(req_data);
   end

   // Driver: hold the item until accepted, then advance or idle.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver ready: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = 3000;
         hold_req  = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Checker: compare each result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_acts.size() == 0) begin
            $display("%0t: unexpected result act=%0d filt=%0d last=%0b", $time,
                     rsp_data.activation, rsp_data.filter_number, rsp_data.last_of_window);
            errors++;
         end else begin
            exp_res = expected_acts.pop_front();
            if (rsp_data !== exp_res) begin
               $display("%0t: mismatch exp act=%0d filt=%0d last=%0b got act=%0d filt=%0d last=%0b",
                        $time, exp_res.activation, exp_res.filter_number,
                        exp_res.last_of_window, rsp_data.activation,
                        rsp_data.filter_number, rsp_data.last_of_window);
               errors++;
            end
         end
      end
   end

   task automatic push_item(logic [2:0] cmd, int idx, logic [31:0] val);
      req_type it;
      it.command = cmd;
      it.index   = 10'(idx);
      it.value   = val;
      pending_items.push_back(it);
   endtask

   // Write one register and mirror it in the shadow copy.
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_IN_ZP:     in_zp = $signed(val[7:0]);
         CSR_OUT_ZP:    out_zp = $signed(val[7:0]);
         CSR_IN_SCALE:  shadow_iscale = val;
         CSR_OUT_SCALE: shadow_oscale = val;
         default: ;
      endcase
   endtask

   // Drain everything, then let a scale load or window finish.
   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_acts.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] wscale_val();
      if ($urandom_range(7) == 0) return $urandom;
      return 32'($signed($urandom_range(32768)) - 16384);
   endfunction

   function automatic logic [31:0] bscale_val();
      if ($urandom_range(7) == 0) return $urandom;
      return 32'($signed($urandom_range(2097152)) - 1048576);
   endfunction

   task automatic load_scales();
      for (int f = 0; f < FLT; f++) begin
         push_item(CMD_LOAD_WSCALE, f, wscale_val());
         push_item(CMD_LOAD_BSCALE, f, bscale_val());
      end
   endtask

   // Random noise or a legal load mixed into the sample stream.
   task automatic push_extra();
      case ($urandom_range(5))
         0: push_item(3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)),
                      $urandom_range(1023), $urandom);
         1: push_item(3'($urandom_range(3)), $urandom_range(1023, WCOUNT), $urandom);
         2: push_item(CMD_LOAD_BIAS, $urandom_range(FLT - 1), $urandom);
         3: push_item(CMD_LOAD_WSCALE, $urandom_range(FLT - 1), wscale_val());
         4: push_item(CMD_LOAD_BSCALE, $urandom_range(FLT - 1), bscale_val());
         default: push_item(CMD_LOAD_WEIGHT, $urandom_range(WCOUNT - 1), $urandom);
      endcase
   endtask

   task automatic stream_samples(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 6) push_extra();
         push_item(CMD_SAMPLE, $urandom_range(1023), $urandom);
      end
   endtask

   initial begin
      in_zp = 0; out_zp = 0;
      shadow_iscale = SCALE_ONE; shadow_oscale = SCALE_ONE;
      line_wp = 0; pix_row = 0; pix_col = 0; chan_cnt = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      csr_write(CSR_IN_ZP, $urandom);
      csr_write(CSR_OUT_ZP, $urandom);
      csr_write(CSR_IN_SCALE, SCALE_ONE);
      csr_write(CSR_OUT_SCALE, SCALE_ONE);

      // unused commands and loads past the end of each store: ignored
      push_item(CMD_UNUSED_LO, 0, 32'hFFFF_FFFF);
      push_item(CMD_UNUSED_MID, 1023, 0);
      push_item(CMD_UNUSED_HI, 512, $urandom);
      push_item(CMD_LOAD_WEIGHT, 1023, 32'h7F);
      push_item(CMD_LOAD_WEIGHT, WCOUNT, 32'h80);
      push_item(CMD_LOAD_BIAS, FLT, 32'h7FFF);
      push_item(CMD_LOAD_WSCALE, 1023, 32'h1000_0000);
      push_item(CMD_LOAD_BSCALE, FLT, 32'h1000_0000);
      // saturating multipliers
      push_item(CMD_LOAD_WSCALE, 0, 32'h7FFF_FFFF);
      push_item(CMD_LOAD_WSCALE, 1, 32'h8000_0000);
      push_item(CMD_LOAD_BSCALE, 0, 32'h7FFF_FFFF);
      push_item(CMD_LOAD_BSCALE, 1, 32'h8000_0000);
      wait_idle();

      // zero output scale: multipliers load as zero
      csr_write(CSR_OUT_SCALE, 32'h0);
      push_item(CMD_LOAD_WSCALE, 2, $urandom);
      push_item(CMD_LOAD_BSCALE, 2, $urandom);
      wait_idle();

      // tiny negative divisor with the most negative input scale
      csr_write(CSR_IN_SCALE, 32'h8000_0000);
      csr_write(CSR_OUT_SCALE, 32'hFFFF_FFFF);
      push_item(CMD_LOAD_WSCALE, 3, 32'h0000_0001);
      push_item(CMD_LOAD_BSCALE, 3, 32'hFFFF_FFFF);
      wait_idle();

      // full setup before any window can close
      csr_write(CSR_IN_SCALE, SCALE_ONE);
      csr_write(CSR_OUT_SCALE, SCALE_ONE);
      push_item(CMD_LOAD_WEIGHT, 0, 32'h0000_007F);
      push_item(CMD_LOAD_WEIGHT, 1, 32'hFFFF_FF80);
      for (int w = 2; w < WCOUNT; w++) push_item(CMD_LOAD_WEIGHT, w, $urandom);
      push_item(CMD_LOAD_BIAS, 0, 32'h0000_7FFF);
      push_item(CMD_LOAD_BIAS, 1, 32'hFFFF_8000);
      for (int f = 2; f < FLT; f++) push_item(CMD_LOAD_BIAS, f, $urandom);
      load_scales();
      push_item(CMD_SAMPLE, 0, 32'h0000_007F);
      push_item(CMD_SAMPLE, 0, 32'hFFFF_FF80);

      // phase 1, no idling: fill the line store, then a few windows
      stream_samples(LDEPTH + 18);
      wait_idle();

      // phase 2, sender idle most cycles
      csr_write(CSR_IN_ZP, 32'h80);
      csr_write(CSR_OUT_ZP, 32'h7F);
      csr_write(CSR_IN_SCALE, 32'h7FFF_FFFF);
      csr_write(CSR_OUT_SCALE, 32'h7FFF_FFFF);
      send_idle_pct = 81;
      load_scales();
      stream_samples(36);
      wait_idle();

      // phase 3, receiver stalls; start with a long hold-off to back up the input
      csr_write(CSR_IN_ZP, 32'h7F);
      csr_write(CSR_OUT_ZP, 32'h80);
      csr_write(CSR_IN_SCALE, 32'h8000_0000);
      csr_write(CSR_OUT_SCALE, 32'h8000_0000);
      send_idle_pct = 0;
      rsp_stall_pct = 81;
      hold_req = 1;
      load_scales();
      stream_samples(36);
      wait_idle();

      // phase 4, both sides idle now and then
      csr_write(CSR_IN_ZP, $urandom);
      csr_write(CSR_OUT_ZP, $urandom);
      csr_write(CSR_IN_SCALE, 32'h0800_0000 + $urandom_range(32'h1000_0000));
      csr_write(CSR_OUT_SCALE, 32'h0800_0000 + $urandom_range(32'h1000_0000));
      send_idle_pct = 26;
      rsp_stall_pct = 26;
      load_scales();
      stream_samples(36);
      wait_idle();

      if (errors == 0 && expected_acts.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
design/qcs_pkg.sv
design/qcs_ram.sv
design/qcs_dp.sv
design/qcs_ctl.sv
design/quantized_conv2d_stream_unit.sv
tb/tb.sv
